### rtl/plsm_pkg.sv
package plsm_pkg;

   localparam int MaxStopsDefault = 16;
   localparam int DataWidth = 32;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_NONE   = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2,
      STATUS_RSVD  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PICK,
      ST_FETCH,
      ST_MUL,
      ST_DIV,
      ST_DONE,
      ST_OUT
   } state_type;

endpackage

### rtl/plsm_if.sv
interface plsm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic signed [31:0] position_in;
   logic signed [31:0] value_in;
   modport source (output valid, command, position_in, value_in, input ready);
   modport sink   (input valid, command, position_in, value_in, output ready);
endinterface

interface plsm_rsp_if #(parameter int CountWidth = 5);
   logic        valid;
   logic        ready;
   logic signed [31:0] mapped_value;
   logic [CountWidth-1:0] stop_count;
   logic [1:0]  status;
   modport source (output valid, mapped_value, stop_count, status, input ready);
   modport sink   (input valid, mapped_value, stop_count, status, output ready);
endinterface

### rtl/plsm_muldiv.sv
module plsm_muldiv
   import plsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] a_in,
   input  logic [32:0] b_in,
   input  logic [31:0] d_in,
   output logic        done,
   output logic [32:0] quotient
);
   // floor(a*b/d) with a < d: product then restoring division, one bit a cycle
   logic [64:0] num_ff, num_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        mul_ff, mul_in;
   logic [31:0] a_ff, a_in_r;
   logic [32:0] b_ff, b_in_r;
   logic [33:0] trial;

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      mul_in = mul_ff;
      a_in_r = a_ff;
      b_in_r = b_ff;
      done = 1'b0;
      trial = {rem_ff, num_ff[64]} - {2'b00, den_ff};
      if (start) begin
         a_in_r = a_in;
         b_in_r = b_in;
         den_in = d_in;
         mul_in = 1'b1;
         busy_in = 1'b1;
      end else if (mul_ff) begin
         num_in = {1'b0, a_ff} * b_ff;
         rem_in = '0;
         cnt_in = 7'd65;
         mul_in = 1'b0;
      end else if (busy_ff) begin
         if (cnt_ff == 7'd0) begin
            busy_in = 1'b0;
            done = 1'b1;
         end else begin
            if (!trial[33]) begin
               rem_in = trial[32:0];
               num_in = {num_ff[63:0], 1'b1};
            end else begin
               rem_in = {rem_ff[31:0], num_ff[64]};
               num_in = {num_ff[63:0], 1'b0};
            end
            cnt_in = cnt_ff - 7'd1;
         end
      end
   end

   assign quotient = num_ff[32:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         mul_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         mul_ff <= mul_in;
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      a_ff <= a_in_r;
      b_ff <= b_in_r;
   end

   a_done_when_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> busy_ff) else $error("done without busy");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("restart while busy");
   a_mul_then_div: assert property (@(posedge clock) disable iff (reset)
      mul_ff |=> busy_ff && cnt_ff == 7'd65) else $error("division not loaded");
endmodule

### rtl/piecewise_linear_stop_mapper_core.sv
// Piecewise-linear stop mapper: holds up to MAX_STOPS Q16.16 (position, value) stops in
// append order in two memories, each with one write and one read port. One item is taken
// at a time. Append, remove and empty-table queries go straight to the output register.
// A query on a held table reads every held stop once and then picks its answer: a clamped
// or exact value, or, when it falls between stops, the result of a multiply and a
// bit-serial 65-step division. The result sits in an output register until taken.
module piecewise_linear_stop_mapper_core
   import plsm_pkg::*;
#(
   parameter int MAX_STOPS = MaxStopsDefault
) (
   input logic clock,
   input logic reset,
   plsm_req_if.sink req,
   plsm_rsp_if.source rsp
);
   localparam int AW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
   localparam int CW = $clog2(MAX_STOPS + 1);

   logic signed [31:0] pos_mem [MAX_STOPS];
   logic signed [31:0] val_mem [MAX_STOPS];

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;      // issued read index
   logic [CW-1:0] ridx_ff, ridx_in;    // index of data now on read port
   logic          rvalid_ff, rvalid_in;
   logic signed [31:0] q_ff, q_in;
   logic signed [31:0] rd_pos_ff, rd_val_ff;
   logic [AW-1:0] raddr;

   logic signed [31:0] minp_ff, minp_in, minv_ff, minv_in;
   logic signed [31:0] maxp_ff, maxp_in, maxv_ff, maxv_in;
   logic signed [31:0] exv_ff, exv_in;
   logic signed [31:0] lp_ff, lp_in, lv_ff, lv_in;
   logic signed [31:0] rp_ff, rp_in, rv_ff, rv_in;
   logic hex_ff, hex_in, hl_ff, hl_in, hr_ff, hr_in;

   logic signed [31:0] out_val_ff, out_val_in;
   logic [1:0]    out_st_ff, out_st_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          wr_en;
   logic [AW-1:0] waddr;

   logic          md_start, md_done;
   logic [32:0]   md_q;
   logic [32:0]   dv_abs;
   logic          dv_neg_ff, dv_neg_in;
   logic signed [32:0] dv_s;

   assign dv_s = {rv_ff[31], rv_ff} - {lv_ff[31], lv_ff};

   plsm_muldiv u_muldiv (
      .clock(clock), .reset(reset), .start(md_start),
      .a_in(32'(q_ff - lp_ff)), .b_in(dv_abs), .d_in(32'(rp_ff - lp_ff)),
      .done(md_done), .quotient(md_q)
   );

   assign dv_abs = dv_s[32] ? 33'(-dv_s) : 33'(dv_s);
   assign raddr = idx_ff[AW-1:0];
   assign waddr = count_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pos_mem[waddr] <= req.position_in;
         val_mem[waddr] <= req.value_in;
      end
      rd_pos_ff <= pos_mem[raddr];
      rd_val_ff <= val_mem[raddr];
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.mapped_value = out_val_ff;
   assign rsp.stop_count = 5'(count_ff);
   assign rsp.status = out_st_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      ridx_in = ridx_ff;
      rvalid_in = 1'b0;
      q_in = q_ff;
      minp_in = minp_ff; minv_in = minv_ff;
      maxp_in = maxp_ff; maxv_in = maxv_ff;
      exv_in = exv_ff;
      lp_in = lp_ff; lv_in = lv_ff; rp_in = rp_ff; rv_in = rv_ff;
      hex_in = hex_ff; hl_in = hl_ff; hr_in = hr_ff;
      out_val_in = out_val_ff;
      out_st_in = out_st_ff;
      rsp_valid_in = rsp_valid_ff;
      dv_neg_in = dv_neg_ff;
      wr_en = 1'b0;
      md_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               out_val_in = '0;
               out_st_in = STATUS_OK;
               q_in = req.position_in;
               state_in = ST_OUT;
               unique case (command_type'(req.command))
                  CMD_APPEND: begin
                     if (count_ff >= CW'(MAX_STOPS)) out_st_in = STATUS_FULL;
                     else begin
                        wr_en = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_REMOVE: begin
                     if (count_ff == '0) out_st_in = STATUS_EMPTY;
                     else count_in = count_ff - 1'b1;
                  end
                  CMD_QUERY: begin
                     if (count_ff != '0) begin
                        idx_in = '0;
                        hex_in = 1'b0; hl_in = 1'b0; hr_in = 1'b0;
                        state_in = ST_SCAN;
                     end
                  end
                  default: ;
               endcase
               if (state_in == ST_OUT) rsp_valid_in = 1'b1;
            end
         end
         ST_SCAN: begin
            if (idx_ff < count_ff) begin
               rvalid_in = 1'b1;
               ridx_in = idx_ff;
               idx_in = idx_ff + 1'b1;
            end
            if (rvalid_ff) begin
               if (ridx_ff == '0 || rd_pos_ff < minp_ff) begin
                  minp_in = rd_pos_ff; minv_in = rd_val_ff;
               end
               if (ridx_ff == '0 || rd_pos_ff >= maxp_ff) begin
                  maxp_in = rd_pos_ff; maxv_in = rd_val_ff;
               end
               if (rd_pos_ff == q_ff) begin
                  exv_in = rd_val_ff; hex_in = 1'b1;
               end
               if (rd_pos_ff < q_ff && (!hl_ff || rd_pos_ff >= lp_ff)) begin
                  lp_in = rd_pos_ff; lv_in = rd_val_ff; hl_in = 1'b1;
               end
               if (rd_pos_ff > q_ff && (!hr_ff || rd_pos_ff < rp_ff)) begin
                  rp_in = rd_pos_ff; rv_in = rd_val_ff; hr_in = 1'b1;
               end
            end
            if (!rvalid_ff && idx_ff >= count_ff && idx_ff != '0) state_in = ST_PICK;
         end
         ST_PICK: begin
            state_in = ST_OUT;
            rsp_valid_in = 1'b1;
            priority if (count_ff == CW'(1)) out_val_in = minv_ff;
            else if (q_ff < minp_ff) out_val_in = minv_ff;
            else if (q_ff > maxp_ff) out_val_in = maxv_ff;
            else if (hex_ff) out_val_in = exv_ff;
            else if (hl_ff && hr_ff) begin
               rsp_valid_in = 1'b0;
               dv_neg_in = dv_s[32];
               md_start = 1'b1;
               state_in = ST_DIV;
            end
            else out_val_in = '0;
         end
         ST_DIV: begin
            if (md_done) begin
               out_val_in = dv_neg_ff ? 32'(lv_ff - md_q[31:0]) : 32'(lv_ff + md_q[31:0]);
               rsp_valid_in = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp.ready) begin
               rsp_valid_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rvalid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rvalid_ff <= rvalid_in;
         idx_ff <= idx_in;
      end
      ridx_ff <= ridx_in;
      q_ff <= q_in;
      minp_ff <= minp_in; minv_ff <= minv_in;
      maxp_ff <= maxp_in; maxv_ff <= maxv_in;
      exv_ff <= exv_in;
      lp_ff <= lp_in; lv_ff <= lv_in; rp_ff <= rp_in; rv_ff <= rv_in;
      hex_ff <= hex_in; hl_ff <= hl_in; hr_ff <= hr_in;
      out_val_ff <= out_val_in;
      out_st_ff <= out_st_in;
      dv_neg_ff <= dv_neg_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_STOPS)) else $error("stop count overflow");
   a_valid_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff == (state_ff == ST_OUT)) else $error("response valid out of step");
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == ST_IDLE && count_ff < CW'(MAX_STOPS))
      else $error("bad write");
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |=> $stable(count_ff)) else $error("count moved during scan");
endmodule
